// File: rtl/fhdw_pkg.sv
`default_nettype none

package fhdw_pkg;

   localparam int HASH_W = 16;
   localparam int TIME_W = 48;
   localparam int WIN_W  = 24;
   localparam int BYTE_W = 8;

   localparam logic [HASH_W-1:0] CRC_INIT     = 16'hFFFF;
   localparam logic [HASH_W-1:0] CRC_POLY     = 16'hA001;
   localparam logic [WIN_W-1:0]  WINDOW_RESET = 24'd500000;

   // register index of the window length
   localparam logic REG_WINDOW = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CRC  = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// File: rtl/fhdw_ram.sv
`default_nettype none

module fhdw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/frame_hash_dedup_window.sv
`default_nettype none

// Duplicate-frame filter on a CRC-16/MODBUS hash. Frame bytes come in one per
// transaction on req_*; each byte is folded into the running CRC one bit per
// cycle by a single shift/xor step, so a byte that is not the last of a frame
// is accepted and then takes eight bit steps before req_tready is high again.
// On the byte flagged with req_tlast the finished hash is compared against the
// slot table held in a RAM, one slot per cycle through the RAM read port and
// one 48-bit subtract/compare unit; the scan stops at the first match. A slot
// matches when its hash is equal and (now_us - slot time), read as a signed
// 48-bit value, is below window_us; a negative difference always matches. On
// no match, hash and time go into the slot under a round-robin pointer. After
// reset every slot reads as hash 0, time 0 (per-slot valid bits, no clearing
// pass). Results leave on rsp_* as one transaction per frame; the block keeps
// taking bytes of the next frame while a result waits in the output register.
// window_us is the only CSR, at byte address 0; write it only while the block
// is idle.
module frame_hash_dedup_window #(
   parameter int NUM_SLOTS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,    // [7:0] frame_byte, [55:8] now_us
   input  wire logic        req_tlast,    // last_byte

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,    // [15:0] hash_value
   output logic             rsp_tuser,    // is_duplicate

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   import fhdw_pkg::*;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int ENTRY_W = HASH_W + TIME_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   // sequencer and control
   state_type            state_ff, state_in;
   logic [2:0]           bit_cnt_ff, bit_cnt_in;
   logic                 last_ff, last_in;
   logic [HASH_W-1:0]    crc_ff, crc_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [WIN_W-1:0]     window_ff, window_in;

   // slot scan
   logic [SLOT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                 issuing_ff, issuing_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic                 cmp_last_ff, cmp_last_in;
   logic                 dup_ff, dup_in;
   logic [SLOT_W-1:0]    next_slot_ff, next_slot_in;
   logic [NUM_SLOTS-1:0] slot_vld_ff, slot_vld_in;
   logic                 rd_vld_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0]    rsp_hash_ff, rsp_hash_in;
   logic                 rsp_dup_ff, rsp_dup_in;

   // RAM side
   logic                 ram_we;
   logic [ENTRY_W-1:0]   ram_rdata;
   logic [HASH_W-1:0]    slot_hash;
   logic [TIME_W-1:0]    slot_time;
   logic [TIME_W-1:0]    time_diff;
   logic                 slot_match;
   logic                 out_free;
   logic                 csr_wr;

   fhdw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (next_slot_ff),
      .wr_data ({crc_ff, now_ff}),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rdata)
   );

   // a slot never written reads as hash 0, time 0
   assign slot_hash = rd_vld_ff ? ram_rdata[ENTRY_W-1:TIME_W] : '0;
   assign slot_time = rd_vld_ff ? ram_rdata[TIME_W-1:0] : '0;

   // shared compare unit: signed age of the slot against the window
   assign time_diff  = now_ff - slot_time;
   assign slot_match = (slot_hash == crc_ff) &&
                       (time_diff[TIME_W-1] ||
                        ((time_diff[TIME_W-1:WIN_W] == '0) &&
                         (time_diff[WIN_W-1:0] < window_ff)));

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign ram_we     = (state_ff == ST_DONE) && out_free && !dup_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_hash_ff;
   assign rsp_tuser  = rsp_dup_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_WINDOW) ? {8'h00, window_ff} : '0;

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      last_in      = last_ff;
      crc_in       = crc_ff;
      now_in       = now_ff;
      window_in    = window_ff;
      scan_idx_in  = scan_idx_ff;
      issuing_in   = issuing_ff;
      cmp_vld_in   = 1'b0;
      cmp_last_in  = cmp_last_ff;
      dup_in       = dup_ff;
      next_slot_in = next_slot_ff;
      slot_vld_in  = slot_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hash_in  = rsp_hash_ff;
      rsp_dup_in   = rsp_dup_ff;

      if (csr_wr && (csr_paddr[2] == REG_WINDOW)) begin
         window_in = csr_pwdata[WIN_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               // fold the byte into the low end, then shift out bit by bit
               crc_in     = crc_ff ^ {8'h00, req_tdata[BYTE_W-1:0]};
               now_in     = req_tdata[BYTE_W +: TIME_W];
               last_in    = req_tlast;
               bit_cnt_in = '0;
               state_in   = ST_CRC;
            end
         end
         ST_CRC: begin
            crc_in     = crc_ff[0] ? ((crc_ff >> 1) ^ CRC_POLY) : (crc_ff >> 1);
            bit_cnt_in = bit_cnt_ff + 3'd1;
            if (bit_cnt_ff == 3'd7) begin
               if (last_ff) begin
                  scan_idx_in = '0;
                  issuing_in  = 1'b1;
                  dup_in      = 1'b0;
                  state_in    = ST_SCAN;
               end else begin
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            // issue one read per cycle, compare the one issued last cycle
            if (issuing_ff) begin
               cmp_vld_in  = 1'b1;
               cmp_last_in = (scan_idx_ff == LAST_SLOT);
               if (scan_idx_ff == LAST_SLOT) begin
                  issuing_in = 1'b0;
               end else begin
                  scan_idx_in = scan_idx_ff + 1'b1;
               end
            end
            if (cmp_vld_ff) begin
               if (slot_match) begin
                  dup_in     = 1'b1;
                  issuing_in = 1'b0;
                  state_in   = ST_DONE;
               end else if (cmp_last_ff) begin
                  state_in   = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = crc_ff;
               rsp_dup_in   = dup_ff;
               crc_in       = CRC_INIT;
               if (!dup_ff) begin
                  slot_vld_in[next_slot_ff] = 1'b1;
                  next_slot_in = (next_slot_ff == LAST_SLOT) ? '0 : next_slot_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         last_ff      <= 1'b0;
         crc_ff       <= CRC_INIT;
         window_ff    <= WINDOW_RESET;
         scan_idx_ff  <= '0;
         issuing_ff   <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         cmp_last_ff  <= 1'b0;
         dup_ff       <= 1'b0;
         next_slot_ff <= '0;
         slot_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         last_ff      <= last_in;
         crc_ff       <= crc_in;
         window_ff    <= window_in;
         scan_idx_ff  <= scan_idx_in;
         issuing_ff   <= issuing_in;
         cmp_vld_ff   <= cmp_vld_in;
         cmp_last_ff  <= cmp_last_in;
         dup_ff       <= dup_in;
         next_slot_ff <= next_slot_in;
         slot_vld_ff  <= slot_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_dup_ff  <= rsp_dup_in;
      rd_vld_ff   <= slot_vld_ff[scan_idx_ff];
   end

`ifndef NO_ASSERTIONS
   // an accepted byte starts the bit-serial fold from its first step
   a_accept_starts_crc: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CRC) && (bit_cnt_ff == 3'd0))
      else $error("accepted byte did not start the CRC fold");

   // the scan is entered only from the last bit step of a frame's last byte
   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_SCAN) |-> $past(last_ff) && ($past(bit_cnt_ff) == 3'd7))
      else $error("slot scan entered outside a last byte");

   // a recorded frame marks its slot as written
   a_slot_marked: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> slot_vld_ff[$past(next_slot_ff)])
      else $error("written slot not marked valid");
`endif

endmodule

`default_nettype wire
